// ----- rtl/core/ppu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants for the particle pool update block.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int PoolSize = 512;
    localparam int IdxW     = $clog2(PoolSize);
    localparam int CntW     = IdxW + 1;

    localparam logic [1:0] OP_SPAWN = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] CFG_LIFE  = 2'd0;
    localparam logic [1:0] CFG_FADE  = 2'd1;
    localparam logic [1:0] CFG_VSCL  = 2'd2;

    localparam logic [30:0] LifeStartRst = 31'd52429;
    localparam logic [30:0] FadeRateRst  = 31'd163840;
    localparam logic [16:0] VelScaleRst  = 17'd6554;

    // Controller to datapath
    typedef struct packed {
        logic          clr_wr;    // write zero entry at clr index
        logic          rd;        // issue read at rd_idx
        logic [IdxW-1:0] rd_idx;
        logic          tick_wb;   // write back tick result of entry read last cycle
        logic [IdxW-1:0] wb_idx;
        logic          spawn_wr;  // write spawned entry at wb_idx
        logic          cnt_clr;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic dead;               // entry read last cycle has life <= 0
    } t_sts;

    // jitter = round((c-50)*65536/10) by reciprocal multiply; never near a tie
    function automatic logic signed [31:0] jitter_lut(input logic [6:0] c);
        logic signed [47:0] p;
        begin
            p = (48'($signed({1'b0, c})) - 48'sd50) * 48'sd429496730 + 48'sd32768;
            jitter_lut = 32'(p >>> 16);
        end
    endfunction

    // shade = 0.5 + round(c*65536/100) by reciprocal multiply
    function automatic logic [16:0] shade_lut(input logic [6:0] c);
        logic [39:0] p;
        begin
            p = 40'(c) * 40'd42949673 + 40'd32768;
            shade_lut = 17'(40'd32768 + (p >> 16));
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        begin
            if (v > 48'sh7FFFFFFF)       sat32 = 32'sh7FFFFFFF;
            else if (v < -48'sh80000000) sat32 = 32'sh80000000;
            else                         sat32 = v[31:0];
        end
    endfunction

    // round to nearest (ties up) of p/65536, p is a 57-bit signed product
    function automatic logic signed [47:0] rnd16(input logic signed [56:0] p);
        logic signed [56:0] t;
        begin
            t = p + 57'sd32768;
            rnd16 = 48'(t >>> 16);
        end
    endfunction

endpackage

// ----- rtl/core/ppu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_ctrl
// Sequencer: clearing pass, spawn search, tick sweep, read, result handoff.
// ----------------------------------------------------------------------------
module ppu_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_fire,
    input  logic [1:0]                i_opcode,
    input  logic [8:0]                i_slot_index,
    input  logic                      i_out_free,
    input  ppu_pkg::t_sts             i_sts,
    output ppu_pkg::t_cmd             o_cmd,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [1:0]                o_op,
    output logic                      o_spawned,
    output logic [ppu_pkg::IdxW-1:0]  o_slot
);
    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_TICK  = 3'd3;
    localparam logic [2:0] S_RDW   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int IdxW = ppu_pkg::IdxW;
    localparam int CntW = ppu_pkg::CntW;
    localparam logic [CntW-1:0] Last = CntW'(ppu_pkg::PoolSize - 1);

    logic [2:0]      r_st, n_st;
    logic [CntW-1:0] r_cnt, n_cnt;      // entries issued
    logic [IdxW-1:0] r_ptr, n_ptr;      // index being issued
    logic [IdxW-1:0] r_pidx, n_pidx;    // index read last cycle
    logic            r_pv, n_pv;        // a read was issued last cycle
    logic [IdxW-1:0] r_start, n_start;
    logic [1:0]      r_op, n_op;
    logic            r_hit, n_hit;
    logic [IdxW-1:0] r_slot, n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_pv    <= 1'b0;
            r_start <= '0;
            r_op    <= ppu_pkg::OP_NOP;
            r_hit   <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            r_pv    <= n_pv;
            r_start <= n_start;
            r_op    <= n_op;
            r_hit   <= n_hit;
        end
        r_pidx <= n_pidx;
        r_slot <= n_slot;
    end

    always_comb begin
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_ptr   = r_ptr;
        n_pidx  = r_ptr;
        n_pv    = 1'b0;
        n_start = r_start;
        n_op    = r_op;
        n_hit   = r_hit;
        n_slot  = r_slot;
        o_cmd   = '0;
        o_cmd.rd_idx = r_ptr;
        o_cmd.wb_idx = r_pidx;
        unique case (r_st)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                n_ptr = r_ptr + 1'b1;
                if (r_cnt == Last) begin
                    n_st = S_IDLE;
                    n_cnt = '0;
                    n_ptr = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_fire) begin
                    n_op  = i_opcode;
                    n_hit = 1'b0;
                    n_cnt = '0;
                    unique case (i_opcode)
                        ppu_pkg::OP_SPAWN: begin
                            n_st = S_SRCH;
                            n_ptr = r_start;
                        end
                        ppu_pkg::OP_TICK: begin
                            n_st = S_TICK;
                            n_ptr = '0;
                            o_cmd.cnt_clr = 1'b1;
                        end
                        ppu_pkg::OP_READ: begin
                            n_slot = IdxW'(i_slot_index);
                            n_ptr  = IdxW'(i_slot_index);
                            n_st   = S_RDW;
                        end
                        default: begin
                            n_slot = '0;
                            n_st   = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (r_pv && i_sts.dead) begin
                    o_cmd.spawn_wr = 1'b1;
                    n_hit   = 1'b1;
                    n_slot  = r_pidx;
                    n_start = r_pidx;
                    n_st    = S_DONE;
                end else if (r_cnt == CntW'(ppu_pkg::PoolSize)) begin
                    n_hit   = 1'b0;
                    n_slot  = '0;
                    n_start = '0;
                    n_st    = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_pv  = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_TICK: begin
                o_cmd.tick_wb = r_pv;
                if (r_cnt == CntW'(ppu_pkg::PoolSize)) begin
                    if (!r_pv) n_st = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_pv  = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RDW: begin
                o_cmd.rd = 1'b1;
                n_pv = 1'b1;
                n_st = S_DONE;
            end
            S_DONE: begin
                // read data registered on the previous edge is held in datapath
                if (i_out_free) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_busy    = (r_st != S_IDLE);
    assign o_done    = (r_st == S_DONE) && i_out_free;
    assign o_op      = r_op;
    assign o_spawned = r_hit;
    assign o_slot    = r_slot;
endmodule

// ----- rtl/core/ppu_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_dpath
// Particle memory, spawn arithmetic and per-entry tick update.
// ----------------------------------------------------------------------------
module ppu_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ppu_pkg::t_cmd              i_cmd,
    output ppu_pkg::t_sts              o_sts,
    input  logic                       i_in_fire,
    input  logic [23:0]                i_step_time,
    input  logic signed [31:0]         i_origin_x,
    input  logic signed [31:0]         i_origin_y,
    input  logic signed [31:0]         i_source_vel_x,
    input  logic signed [31:0]         i_source_vel_y,
    input  logic signed [31:0]         i_shift_x,
    input  logic signed [31:0]         i_shift_y,
    input  logic [6:0]                 i_jitter_code,
    input  logic [6:0]                 i_shade_code,
    input  logic [30:0]                i_life_start,
    input  logic [30:0]                i_fade_rate,
    input  logic [16:0]                i_velocity_scale,
    output logic [9:0]                 o_live_count,
    output logic                       o_alive,
    output logic signed [31:0]         o_pos_x,
    output logic signed [31:0]         o_pos_y,
    output logic [16:0]                o_shade,
    output logic signed [31:0]         o_alpha
);
    localparam int IdxW = ppu_pkg::IdxW;
    localparam int EW   = 32 * 6 + 17;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] life;
        logic [16:0]        shade;
        logic signed [31:0] alpha;
    } t_ent;

    logic [EW-1:0] r_mem [ppu_pkg::PoolSize];
    t_ent          r_rd;
    t_ent          n_wr;
    logic          wr_en;
    logic [IdxW-1:0] wr_idx;

    // latched item operands
    logic [23:0]        r_dt;
    logic signed [31:0] r_sx, r_sy;
    logic signed [31:0] r_vx_a, r_vy_a;
    logic [16:0]        r_sh;
    logic signed [47:0] r_fade;
    logic [9:0]         r_live;

    logic signed [47:0] fade_w;
    logic signed [47:0] vxs_w, vys_w;
    logic signed [56:0] fp;

    assign fp = $signed({26'd0, i_fade_rate}) * $signed({33'd0, i_step_time});

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_dt   <= i_step_time;
            r_sx   <= ppu_pkg::sat32(48'(i_origin_x) + 48'(ppu_pkg::jitter_lut(i_jitter_code))
                                     + 48'(i_shift_x));
            r_sy   <= ppu_pkg::sat32(48'(i_origin_y) + 48'(ppu_pkg::jitter_lut(i_jitter_code))
                                     + 48'(i_shift_y));
            r_sh   <= ppu_pkg::shade_lut(i_shade_code);
            r_vx_a <= ppu_pkg::sat32(vxs_w);
            r_vy_a <= ppu_pkg::sat32(vys_w);
            r_fade <= fade_w;
        end
    end

    assign vxs_w  = ppu_pkg::rnd16(57'(i_source_vel_x * $signed({1'b0, i_velocity_scale})));
    assign vys_w  = ppu_pkg::rnd16(57'(i_source_vel_y * $signed({1'b0, i_velocity_scale})));
    assign fade_w = ppu_pkg::rnd16(fp);

    // tick update of the entry read last cycle
    t_ent               tk;
    logic signed [47:0] lf;
    logic signed [31:0] nlife;
    logic signed [56:0] pvx, pvy;
    always_comb begin
        lf    = 48'(r_rd.life) - 48'($signed({1'b0, r_dt}));
        nlife = ppu_pkg::sat32(lf);
        pvx   = 57'(r_rd.vx * $signed({1'b0, r_dt}));
        pvy   = 57'(r_rd.vy * $signed({1'b0, r_dt}));
        tk    = r_rd;
        tk.life = nlife;
        if (nlife > 0) begin
            tk.px    = ppu_pkg::sat32(48'(r_rd.px) - ppu_pkg::rnd16(pvx));
            tk.py    = ppu_pkg::sat32(48'(r_rd.py) - ppu_pkg::rnd16(pvy));
            tk.alpha = ppu_pkg::sat32(48'(r_rd.alpha) - r_fade);
        end
    end

    always_comb begin
        n_wr   = tk;
        wr_en  = 1'b0;
        wr_idx = i_cmd.wb_idx;
        priority if (i_cmd.clr_wr) begin
            n_wr   = '0;
            wr_en  = 1'b1;
            wr_idx = i_cmd.rd_idx;
        end else if (i_cmd.spawn_wr) begin
            n_wr.px    = r_sx;
            n_wr.py    = r_sy;
            n_wr.vx    = r_vx_a;
            n_wr.vy    = r_vy_a;
            n_wr.life  = $signed({1'b0, i_life_start});
            n_wr.shade = r_sh;
            n_wr.alpha = 32'sd65536;
            wr_en      = 1'b1;
        end else if (i_cmd.tick_wb) begin
            wr_en = 1'b1;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_idx] <= n_wr;
        if (i_cmd.rd) r_rd <= r_mem[i_cmd.rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cnt_clr) begin
            r_live <= '0;
        end else if (i_cmd.tick_wb && nlife > 0 && r_live != 10'd1023) begin
            r_live <= r_live + 1'b1;
        end
    end

    assign o_sts.dead   = (r_rd.life <= 0);
    assign o_live_count = r_live;
    assign o_alive      = (r_rd.life > 0);
    assign o_pos_x      = r_rd.px;
    assign o_pos_y      = r_rd.py;
    assign o_shade      = r_rd.shade;
    assign o_alpha      = r_rd.alpha;
endmodule

// ----- rtl/core/particle_pool_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_update
// Particle pool with spawn search, tick sweep and slot read.
// ----------------------------------------------------------------------------
// One item at a time through a pool memory with one read and one write port,
// one entry per cycle. After reset a clearing pass zeroes all 512 entries of
// the pool; no item is taken then. A read fetches the addressed slot, a spawn
// searches until a dead slot (a full pass on a miss), a tick sweeps the whole
// pool and ends with the last write-back. The next item is taken from the
// cycle after the result is loaded; while an older result still waits on
// m_axis_tready the new one waits too.
module particle_pool_update (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[1:0] step_time[25:2] origin_x[57:26] origin_y[89:58]
    // source_vel_x[121:90] source_vel_y[153:122] shift_x[185:154]
    // shift_y[217:186] jitter_code[224:218] shade_code[231:225]
    // slot_index[240:232], zero fill to 248
    input  logic [247:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // spawned[0] slot[9:1] live_count[19:10] alive[20] pos_x[52:21]
    // pos_y[84:53] shade[101:85] alpha[133:102], zero fill to 136
    output logic [135:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data
);
    ppu_pkg::t_cmd cmd;
    ppu_pkg::t_sts sts;

    logic [30:0] r_life_start, r_fade_rate;
    logic [16:0] r_vel_scale;
    logic        busy, done, spawned_c, in_fire, out_free;
    logic [1:0]  op;
    logic [ppu_pkg::IdxW-1:0] slot_c;
    logic [9:0]  live_c;
    logic        alive_c;
    logic signed [31:0] px_c, py_c, al_c;
    logic [16:0] sh_c;
    logic        r_ov;
    logic [133:0] r_od, n_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life_start <= ppu_pkg::LifeStartRst;
            r_fade_rate  <= ppu_pkg::FadeRateRst;
            r_vel_scale  <= ppu_pkg::VelScaleRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppu_pkg::CFG_LIFE: r_life_start <= i_cfg_data;
                ppu_pkg::CFG_FADE: r_fade_rate  <= i_cfg_data;
                ppu_pkg::CFG_VSCL: r_vel_scale  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;

    ppu_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_fire    (in_fire),
        .i_opcode     (s_axis_tdata[1:0]),
        .i_slot_index (s_axis_tdata[240:232]),
        .i_out_free   (out_free),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_busy       (busy),
        .o_done       (done),
        .o_op         (op),
        .o_spawned    (spawned_c),
        .o_slot       (slot_c)
    );

    ppu_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_in_fire        (in_fire),
        .i_step_time      (s_axis_tdata[25:2]),
        .i_origin_x       (s_axis_tdata[57:26]),
        .i_origin_y       (s_axis_tdata[89:58]),
        .i_source_vel_x   (s_axis_tdata[121:90]),
        .i_source_vel_y   (s_axis_tdata[153:122]),
        .i_shift_x        (s_axis_tdata[185:154]),
        .i_shift_y        (s_axis_tdata[217:186]),
        .i_jitter_code    (s_axis_tdata[224:218]),
        .i_shade_code     (s_axis_tdata[231:225]),
        .i_life_start     (r_life_start),
        .i_fade_rate      (r_fade_rate),
        .i_velocity_scale (r_vel_scale),
        .o_live_count     (live_c),
        .o_alive          (alive_c),
        .o_pos_x          (px_c),
        .o_pos_y          (py_c),
        .o_shade          (sh_c),
        .o_alpha          (al_c)
    );

    always_comb begin
        n_od = '0;
        unique case (op)
            ppu_pkg::OP_SPAWN: begin
                n_od[0]   = spawned_c;
                n_od[9:1] = 9'(slot_c);
            end
            ppu_pkg::OP_TICK: n_od[19:10] = live_c;
            ppu_pkg::OP_READ: begin
                n_od[9:1]     = 9'(slot_c);
                n_od[20]      = alive_c;
                n_od[52:21]   = px_c;
                n_od[84:53]   = py_c;
                n_od[101:85]  = sh_c;
                n_od[133:102] = al_c;
            end
            default: n_od = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (done) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
        if (done) r_od <= n_od;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b00, r_od};

    a_no_in_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !in_fire) else $error("item accepted while busy");
    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> m_axis_tvalid) else $error("result lost");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.clr_wr, cmd.spawn_wr, cmd.tick_wb}) <= 1)
        else $error("conflicting pool writes");
endmodule
